@@ sv/ordered_key_set_successor_defines.svh @@
// assertion macros used by the checker file
`ifndef ORDERED_KEY_SET_SUCCESSOR_DEFINES_SVH
`define ORDERED_KEY_SET_SUCCESSOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define OKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define OKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/oks_pkg.sv @@
// ----------------------------------------------------------------------------
// oks_pkg
// Types, constants and bit-search helpers of the ordered key set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oks_pkg;

  // key split into a row address and a bit position in the row
  localparam int KEY_BITS = 7;
  localparam int LO_BITS  = (KEY_BITS + 1) / 2;
  localparam int HI_BITS  = KEY_BITS - LO_BITS;
  localparam int ROW_W    = 1 << LO_BITS;
  localparam int NROWS    = 1 << HI_BITS;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [LO_BITS-1:0]  lo_t;
  typedef logic [HI_BITS-1:0]  hi_t;
  typedef logic [ROW_W-1:0]    row_t;
  typedef logic [NROWS-1:0]    summ_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SUCC   = 2'd2,
    REQ_PRED   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_NBR,
    ST_BND,
    ST_MIN,
    ST_MAX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic rd_en;
    hi_t  rd_addr;
    logic wr_en;
    hi_t  wr_addr;
    row_t wr_data;
  } ram_req_t;

  typedef struct packed {
    logic found;
    key_t neighbor_key;
    logic set_empty;
    key_t smallest;
    key_t largest;
  } rslt_t;

  // lowest set bit of a row
  function automatic lo_t row_first(row_t v);
    lo_t r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) r = lo_t'(i);
    end
    return r;
  endfunction

  // highest set bit of a row
  function automatic lo_t row_last(row_t v);
    lo_t r;
    r = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (v[i]) r = lo_t'(i);
    end
    return r;
  endfunction

  // lowest nonempty row
  function automatic hi_t sum_first(summ_t v);
    hi_t r;
    r = '0;
    for (int i = NROWS - 1; i >= 0; i--) begin
      if (v[i]) r = hi_t'(i);
    end
    return r;
  endfunction

  // highest nonempty row
  function automatic hi_t sum_last(summ_t v);
    hi_t r;
    r = '0;
    for (int i = 0; i < NROWS; i++) begin
      if (v[i]) r = hi_t'(i);
    end
    return r;
  endfunction

  // bits strictly above / below a position in a row
  function automatic row_t row_above(lo_t p);
    row_t m;
    for (int i = 0; i < ROW_W; i++) m[i] = (i > int'(p));
    return m;
  endfunction

  function automatic row_t row_below(lo_t p);
    row_t m;
    for (int i = 0; i < ROW_W; i++) m[i] = (i < int'(p));
    return m;
  endfunction

  // rows strictly above / below a row address
  function automatic summ_t sum_above(hi_t p);
    summ_t m;
    for (int i = 0; i < NROWS; i++) m[i] = (i > int'(p));
    return m;
  endfunction

  function automatic summ_t sum_below(hi_t p);
    summ_t m;
    for (int i = 0; i < NROWS; i++) m[i] = (i < int'(p));
    return m;
  endfunction

endpackage

`default_nettype wire

@@ sv/oks_row_ram.sv @@
// ----------------------------------------------------------------------------
// oks_row_ram
// Presence bitmap rows, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oks_row_ram (
  input  wire logic              clk,
  input  wire oks_pkg::ram_req_t ram_req,
  output      oks_pkg::row_t     rd_data
);

  oks_pkg::row_t mem [oks_pkg::NROWS];
  oks_pkg::row_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (ram_req.wr_en) begin
      mem[ram_req.wr_addr] <= ram_req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (ram_req.rd_en) begin
      rd_data_r <= mem[ram_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/oks_ctrl.sv @@
// ----------------------------------------------------------------------------
// oks_ctrl
// Request sequencer: row read-modify-write, row summary, neighbor search and
// bound refresh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oks_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic [1:0]        in_req_type,
  input  wire oks_pkg::key_t     in_key,
  output      oks_pkg::ram_req_t ram_req,
  input  wire oks_pkg::row_t     rd_data,
  input  wire logic              out_free,
  output      logic              done,
  output      oks_pkg::rslt_t    rslt
);

  oks_pkg::state_e state_r, state_nxt;
  oks_pkg::req_e   req_r, req_nxt;
  oks_pkg::key_t   key_r, key_nxt;
  oks_pkg::summ_t  summ_r, summ_nxt;
  oks_pkg::hi_t    sel_r, sel_nxt;
  logic            found_r, found_nxt;
  oks_pkg::key_t   nb_r, nb_nxt;
  oks_pkg::key_t   min_r, min_nxt;
  oks_pkg::key_t   max_r, max_nxt;

  oks_pkg::hi_t    hi_k;
  oks_pkg::lo_t    lo_k;
  oks_pkg::row_t   row_v, bit_k, new_row, up_bits, dn_bits;
  oks_pkg::summ_t  up_rows, dn_rows;
  logic            has_k;

  // decode of the key row
  assign hi_k    = key_r[oks_pkg::KEY_BITS-1:oks_pkg::LO_BITS];
  assign lo_k    = key_r[oks_pkg::LO_BITS-1:0];
  assign row_v   = summ_r[hi_k] ? rd_data : '0;
  assign bit_k   = oks_pkg::row_t'(1) << lo_k;
  assign has_k   = |(row_v & bit_k);
  assign new_row = (req_r == oks_pkg::REQ_INSERT) ? (row_v | bit_k) : (row_v & ~bit_k);
  assign up_bits = row_v & oks_pkg::row_above(lo_k);
  assign dn_bits = row_v & oks_pkg::row_below(lo_k);
  assign up_rows = summ_r & oks_pkg::sum_above(hi_k);
  assign dn_rows = summ_r & oks_pkg::sum_below(hi_k);

  assign in_stall = (state_r != oks_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oks_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = oks_pkg::ST_ROW;
      end
      oks_pkg::ST_ROW: begin
        case (req_r)
          oks_pkg::REQ_INSERT: state_nxt = has_k ? oks_pkg::ST_DONE : oks_pkg::ST_BND;
          oks_pkg::REQ_DELETE: state_nxt = has_k ? oks_pkg::ST_BND : oks_pkg::ST_DONE;
          oks_pkg::REQ_SUCC: begin
            state_nxt = (!(|up_bits) && (|up_rows)) ? oks_pkg::ST_NBR : oks_pkg::ST_DONE;
          end
          oks_pkg::REQ_PRED: begin
            state_nxt = (!(|dn_bits) && (|dn_rows)) ? oks_pkg::ST_NBR : oks_pkg::ST_DONE;
          end
          default: state_nxt = oks_pkg::ST_DONE;
        endcase
      end
      oks_pkg::ST_BND:  state_nxt = (|summ_r) ? oks_pkg::ST_MIN : oks_pkg::ST_DONE;
      oks_pkg::ST_NBR:  state_nxt = oks_pkg::ST_DONE;
      oks_pkg::ST_MIN:  state_nxt = oks_pkg::ST_MAX;
      oks_pkg::ST_MAX:  state_nxt = oks_pkg::ST_DONE;
      oks_pkg::ST_DONE: begin
        if (out_free) state_nxt = oks_pkg::ST_IDLE;
      end
      default: state_nxt = oks_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    req_nxt   = req_r;
    key_nxt   = key_r;
    summ_nxt  = summ_r;
    sel_nxt   = sel_r;
    found_nxt = found_r;
    nb_nxt    = nb_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ram_req   = '0;
    done      = 1'b0;
    case (state_r)
      oks_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt         = oks_pkg::req_e'(in_req_type);
          key_nxt         = in_key;
          found_nxt       = 1'b0;
          nb_nxt          = '0;
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = in_key[oks_pkg::KEY_BITS-1:oks_pkg::LO_BITS];
        end
      end
      oks_pkg::ST_ROW: begin
        case (req_r)
          oks_pkg::REQ_INSERT, oks_pkg::REQ_DELETE: begin
            if ((req_r == oks_pkg::REQ_INSERT) != has_k) begin
              ram_req.wr_en   = 1'b1;
              ram_req.wr_addr = hi_k;
              ram_req.wr_data = new_row;
              summ_nxt[hi_k]  = |new_row;
            end
          end
          oks_pkg::REQ_SUCC: begin
            if (|up_bits) begin
              found_nxt = 1'b1;
              nb_nxt    = {hi_k, oks_pkg::row_first(up_bits)};
            end else if (|up_rows) begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = oks_pkg::sum_first(up_rows);
              sel_nxt         = oks_pkg::sum_first(up_rows);
            end
          end
          oks_pkg::REQ_PRED: begin
            if (|dn_bits) begin
              found_nxt = 1'b1;
              nb_nxt    = {hi_k, oks_pkg::row_last(dn_bits)};
            end else if (|dn_rows) begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = oks_pkg::sum_last(dn_rows);
              sel_nxt         = oks_pkg::sum_last(dn_rows);
            end
          end
          default: ;
        endcase
      end
      oks_pkg::ST_NBR: begin
        found_nxt = 1'b1;
        nb_nxt    = (req_r == oks_pkg::REQ_SUCC) ? {sel_r, oks_pkg::row_first(rd_data)}
                                                 : {sel_r, oks_pkg::row_last(rd_data)};
      end
      oks_pkg::ST_BND: begin
        if (|summ_r) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = oks_pkg::sum_first(summ_r);
          sel_nxt         = oks_pkg::sum_first(summ_r);
        end else begin
          min_nxt = '0;
          max_nxt = '0;
        end
      end
      oks_pkg::ST_MIN: begin
        min_nxt         = {sel_r, oks_pkg::row_first(rd_data)};
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = oks_pkg::sum_last(summ_r);
        sel_nxt         = oks_pkg::sum_last(summ_r);
      end
      oks_pkg::ST_MAX: begin
        max_nxt = {sel_r, oks_pkg::row_last(rd_data)};
      end
      oks_pkg::ST_DONE: begin
        done = out_free;
      end
      default: ;
    endcase
  end

  // result fields
  assign rslt.found        = found_r;
  assign rslt.neighbor_key = nb_r;
  assign rslt.set_empty    = ~(|summ_r);
  assign rslt.smallest     = min_r;
  assign rslt.largest      = max_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oks_pkg::ST_IDLE;
      summ_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
    end else begin
      state_r <= state_nxt;
      summ_r  <= summ_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // request payload and search results
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    key_r   <= key_nxt;
    sel_r   <= sel_nxt;
    found_r <= found_nxt;
    nb_r    <= nb_nxt;
  end

endmodule

`default_nettype wire

@@ sv/ordered_key_set_successor.sv @@
// Ordered key set over 7-bit keys with strict successor/predecessor search.
// Input channel: in_valid/in_stall with in_req_type (0 insert, 1 delete,
// 2 successor, 3 predecessor) and in_key. Output channel: out_valid/out_stall
// with out_found, out_neighbor_key, out_set_empty, out_smallest, out_largest.
// One result per request. The block handles one request at a time, and each
// request reads the registered row memory (min/max rows only if nonempty):
//   query in the key's row or with no neighbor: key's row only
//   query that reads a second row:               key's row, then neighbor row
//   unchanged insert or delete:                  key's row only
//   insert or delete that changes the set:       key's row, min and max rows
// The next request is taken the cycle after the result enters the output
// register. Reset (rst_n low, synchronous) empties the set at once: the row
// summary flags gate the memory, so no clearing pass is needed. While the
// receiver stalls, the result holds in the output register and a finished
// request waits in the sequencer; input is stalled meanwhile.
// ----------------------------------------------------------------------------
// ordered_key_set_successor
// Top level: row memory, sequencer and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_key_set_successor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [1:0]                       in_req_type,
  input  wire logic [oks_pkg::KEY_BITS-1:0]     in_key,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic                             out_found,
  output      logic [oks_pkg::KEY_BITS-1:0]     out_neighbor_key,
  output      logic                             out_set_empty,
  output      logic [oks_pkg::KEY_BITS-1:0]     out_smallest,
  output      logic [oks_pkg::KEY_BITS-1:0]     out_largest
);

  oks_pkg::ram_req_t ram_req;
  oks_pkg::row_t     rd_data;
  oks_pkg::rslt_t    rslt;
  oks_pkg::rslt_t    out_r;
  logic              done;
  logic              out_free;
  logic              out_valid_r, out_valid_nxt;

  // row memory
  oks_row_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rd_data (rd_data)
  );

  // request sequencer
  oks_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .ram_req     (ram_req),
    .rd_data     (rd_data),
    .out_free    (out_free),
    .done        (done),
    .rslt        (rslt)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= rslt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_r.found;
  assign out_neighbor_key = out_r.neighbor_key;
  assign out_set_empty    = out_r.set_empty;
  assign out_smallest     = out_r.smallest;
  assign out_largest      = out_r.largest;

endmodule

`default_nettype wire

@@ sv/oks_checker.sv @@
// ----------------------------------------------------------------------------
// oks_checker
// Port-level checks of the ordered key set results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_key_set_successor_defines.svh"

module oks_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_found,
  input wire logic [oks_pkg::KEY_BITS-1:0] out_neighbor_key,
  input wire logic                         out_set_empty,
  input wire logic [oks_pkg::KEY_BITS-1:0] out_smallest,
  input wire logic [oks_pkg::KEY_BITS-1:0] out_largest
);

  // stalled result holds
  `OKS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_neighbor_key) && $stable(out_smallest), "stalled result changed")
  // a neighbor needs a nonempty set
  `OKS_ASSERT_NOW(a_found_nonempty, out_valid && out_found, !out_set_empty, "neighbor found in empty set")
  // empty set reports zero bounds
  `OKS_ASSERT_NOW(a_empty_bounds, out_valid && out_set_empty, out_smallest == '0 && out_largest == '0, "empty set bounds nonzero")
  // bounds are ordered
  `OKS_ASSERT_NOW(a_bound_order, out_valid && !out_set_empty, out_smallest <= out_largest, "minimum above maximum")
  // no neighbor reads as zero
  `OKS_ASSERT_NOW(a_miss_zero, out_valid && !out_found, out_neighbor_key == '0, "missing neighbor nonzero")

endmodule

bind ordered_key_set_successor oks_checker u_oks_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_neighbor_key (out_neighbor_key),
  .out_set_empty    (out_set_empty),
  .out_smallest     (out_smallest),
  .out_largest      (out_largest)
);

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered key set. A directed table covers the
// empty set, the extreme keys, duplicate inserts, absent deletes and
// neighbor-less queries. A random phase follows, weighted toward queries on a
// populated set. Results are checked against a bitmap model of the set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int NUM_RANDOM  = 1880;
  localparam int CYCLE_LIMIT = 400000;
  localparam int UNIV        = 1 << oks_pkg::KEY_BITS;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  oks_pkg::key_t in_key;
  logic out_valid;
  logic out_stall;
  logic out_found;
  oks_pkg::key_t out_neighbor_key;
  logic out_set_empty;
  oks_pkg::key_t out_smallest;
  oks_pkg::key_t out_largest;

  ordered_key_set_successor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_key(in_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_found(out_found), .out_neighbor_key(out_neighbor_key),
    .out_set_empty(out_set_empty), .out_smallest(out_smallest),
    .out_largest(out_largest)
  );

  // directed request table; has_exp marks rows with a typed-in answer
  typedef struct {
    oks_pkg::req_e  op;
    oks_pkg::key_t  key;
    logic           has_exp;
    oks_pkg::rslt_t exp;
  } row_entry_t;

  row_entry_t      directed_rows[$];
  oks_pkg::rslt_t  pending_rslt[$];
  logic [UNIV-1:0] key_bitmap;
  int mismatch_cnt;
  int table_err_cnt;
  int cycle_cnt;
  logic long_hold;

  // model: apply one request, return the result it causes
  function automatic oks_pkg::rslt_t keyset_apply(oks_pkg::req_e op, oks_pkg::key_t k);
    oks_pkg::rslt_t r;
    int i;
    r = '0;
    case (op)
      oks_pkg::REQ_INSERT: key_bitmap[k] = 1'b1;
      oks_pkg::REQ_DELETE: key_bitmap[k] = 1'b0;
      oks_pkg::REQ_SUCC: begin
        for (i = int'(k) + 1; i < UNIV; i++) begin
          if (key_bitmap[i] && !r.found) begin
            r.found = 1'b1;
            r.neighbor_key = oks_pkg::key_t'(i);
          end
        end
      end
      default: begin
        for (i = int'(k) - 1; i >= 0; i--) begin
          if (key_bitmap[i] && !r.found) begin
            r.found = 1'b1;
            r.neighbor_key = oks_pkg::key_t'(i);
          end
        end
      end
    endcase
    r.set_empty = (key_bitmap == '0);
    for (i = UNIV - 1; i >= 0; i--) if (key_bitmap[i]) r.smallest = oks_pkg::key_t'(i);
    for (i = 0; i < UNIV; i++) if (key_bitmap[i]) r.largest = oks_pkg::key_t'(i);
    return r;
  endfunction

  function automatic oks_pkg::rslt_t mk_rslt(logic f, oks_pkg::key_t nb, logic e,
                                             oks_pkg::key_t lo, oks_pkg::key_t hi);
    oks_pkg::rslt_t r;
    r.found = f;
    r.neighbor_key = nb;
    r.set_empty = e;
    r.smallest = lo;
    r.largest = hi;
    return r;
  endfunction

  task automatic add_row(oks_pkg::req_e op, oks_pkg::key_t k, logic has, oks_pkg::rslt_t e);
    row_entry_t t;
    t.op = op;
    t.key = k;
    t.has_exp = has;
    t.exp = e;
    directed_rows.push_back(t);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // request a pending result is compared against
  task automatic send_request(oks_pkg::req_e op, oks_pkg::key_t k, logic has,
                              oks_pkg::rslt_t e);
    oks_pkg::rslt_t m;
    int gap;
    m = keyset_apply(op, k);
    if (has && m != e) begin
      table_err_cnt++;
      if (table_err_cnt <= 10)
        $display("table entry disagrees with model: op %s key %0d exp %h model %h",
                 op.name(), k, e, m);
    end
    pending_rslt.push_back(m);
    in_valid <= 1'b1;
    in_req_type <= op;
    in_key <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // burst end: random gap
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stall pattern, plus one long hold-off
  initial begin
    int mode;
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 1) == 1);
        else if (mode == 2) out_stall <= ($urandom_range(0, 7) != 0);
        else out_stall <= ($urandom_range(0, 7) == 0);
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    oks_pkg::rslt_t got;
    oks_pkg::rslt_t exp;
    if (rst_n && out_valid && !out_stall) begin
      got = mk_rslt(out_found, out_neighbor_key, out_set_empty, out_smallest, out_largest);
      if (pending_rslt.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        exp = pending_rslt.pop_front();
        if (got !== exp) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp found %b nb %0d empty %b min %0d max %0d / got %b %0d %b %0d %0d",
                     exp.found, exp.neighbor_key, exp.set_empty, exp.smallest, exp.largest,
                     got.found, got.neighbor_key, got.set_empty, got.smallest, got.largest);
        end
      end
    end
  end

  // stimulus
  initial begin
    oks_pkg::req_e op;
    oks_pkg::key_t k;
    int r;
    int n;
    long_hold = 1'b0;
    key_bitmap = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = oks_pkg::REQ_INSERT;
    in_key = '0;

    // empty set, extremes, duplicates, absent deletes, no neighbor
    add_row(oks_pkg::REQ_SUCC,   7'd0,   1'b1,
            mk_rslt(1'b0, 7'd0, 1'b1, 7'd0, 7'd0));
    add_row(oks_pkg::REQ_PRED,   7'd127, 1'b1,
            mk_rslt(1'b0, 7'd0, 1'b1, 7'd0, 7'd0));
    add_row(oks_pkg::REQ_DELETE, 7'd5,   1'b1,
            mk_rslt(1'b0, 7'd0, 1'b1, 7'd0, 7'd0));
    add_row(oks_pkg::REQ_INSERT, 7'd127, 1'b1,
            mk_rslt(1'b0, 7'd0, 1'b0, 7'd127, 7'd127));
    add_row(oks_pkg::REQ_SUCC,   7'd127, 1'b1,
            mk_rslt(1'b0, 7'd0, 1'b0, 7'd127, 7'd127));
    add_row(oks_pkg::REQ_PRED,   7'd127, 1'b1,
            mk_rslt(1'b0, 7'd0, 1'b0, 7'd127, 7'd127));
    add_row(oks_pkg::REQ_SUCC,   7'd0,   1'b1,
            mk_rslt(1'b1, 7'd127, 1'b0, 7'd127, 7'd127));
    add_row(oks_pkg::REQ_INSERT, 7'd0,   1'b1,
            mk_rslt(1'b0, 7'd0, 1'b0, 7'd0, 7'd127));
    add_row(oks_pkg::REQ_INSERT, 7'd0,   1'b1,
            mk_rslt(1'b0, 7'd0, 1'b0, 7'd0, 7'd127));
    add_row(oks_pkg::REQ_PRED,   7'd0,   1'b1,
            mk_rslt(1'b0, 7'd0, 1'b0, 7'd0, 7'd127));
    add_row(oks_pkg::REQ_PRED,   7'd127, 1'b1,
            mk_rslt(1'b1, 7'd0, 1'b0, 7'd0, 7'd127));
    add_row(oks_pkg::REQ_INSERT, 7'd64,  1'b0, '0);
    add_row(oks_pkg::REQ_INSERT, 7'd63,  1'b0, '0);
    add_row(oks_pkg::REQ_SUCC,   7'd63,  1'b0, '0);
    add_row(oks_pkg::REQ_PRED,   7'd64,  1'b0, '0);
    add_row(oks_pkg::REQ_DELETE, 7'd42,  1'b0, '0);
    add_row(oks_pkg::REQ_DELETE, 7'd64,  1'b0, '0);
    add_row(oks_pkg::REQ_SUCC,   7'd63,  1'b0, '0);
    add_row(oks_pkg::REQ_DELETE, 7'd0,   1'b0, '0);
    add_row(oks_pkg::REQ_DELETE, 7'd63,  1'b0, '0);
    add_row(oks_pkg::REQ_DELETE, 7'd127, 1'b1,
            mk_rslt(1'b0, 7'd0, 1'b1, 7'd0, 7'd0));
    add_row(oks_pkg::REQ_INSERT, 7'd85,  1'b0, '0);
    add_row(oks_pkg::REQ_INSERT, 7'd42,  1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].key,
                   directed_rows[i].has_exp, directed_rows[i].exp);

    // random phase: keep the set populated, then drain it now and then
    for (n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) long_hold = 1'b1;
      r = $urandom_range(0, 99);
      k = oks_pkg::key_t'($urandom_range(0, UNIV - 1));
      if ((n / 300) % 2 == 1 && r < 45) op = oks_pkg::REQ_DELETE;
      else if (r < 30) op = oks_pkg::REQ_INSERT;
      else if (r < 45) op = oks_pkg::REQ_DELETE;
      else if (r < 72) op = oks_pkg::REQ_SUCC;
      else op = oks_pkg::REQ_PRED;
      send_request(op, k, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_rslt.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && table_err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/oks_pkg.sv
sv/oks_row_ram.sv
sv/oks_ctrl.sv
sv/ordered_key_set_successor.sv
sv/oks_checker.sv
bench/tb.sv
